// ----- sv/lrf_pkg.sv -----
// Shared types and fixed widths for the least-squares line fit block.
// No dependencies; every other file imports this package.
package lrf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FIX_W       = 32;   // Q16.16 results
    localparam int RSUM_W      = 64;   // Q48.16 residual sum
    localparam int SUMX_W      = 23;   // running sum of samples
    localparam int SUMXX_W     = 38;   // running sum of products
    localparam int NEXT_W      = 8;    // point count as a signed operand
    localparam int PROD_W      = 46;   // n*sum_xx and sum_x*sum_x
    localparam int SXX_W       = 47;   // centered sums
    localparam int NUM_W       = 56;   // intercept numerator
    localparam int DIV_W       = 64;   // divider dividend and quotient
    localparam int DVS_W       = 44;   // divider divisor
    localparam int FRAC_W      = 16;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [FIX_W-1:0]       fix_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic sum_mul;
        logic sum_sub;
        logic sdiv_go;
        logic slope_take;
        logic icpt_mul;
        logic icpt_num;
        logic idiv_go;
        logic icpt_take;
        logic idx_clr;
        logic idx_inc;
        logic rd;
        logic mul;
        logic fit;
        logic sq;
        logic acc;
        logic clr_set;
    } lrf_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic degen;
        logic div_done;
        logic idx_last;
    } lrf_stat_t;

endpackage

// ----- sv/lrf_if.sv -----
// Valid/ready channel interfaces for sample items and result items.
// Depends on lrf_pkg.
interface lrf_in_if import lrf_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t x_value;
    sample_t y_value;
    logic    last_point;

    modport source (output valid, x_value, y_value, last_point, input ready);
    modport sink   (input valid, x_value, y_value, last_point, output ready);
endinterface

interface lrf_out_if import lrf_pkg::*; ();
    logic              valid;
    logic              ready;
    fix_t              fitted_value;
    fix_t              slope;
    fix_t              intercept;
    logic [RSUM_W-1:0] residual_sum;
    logic              degenerate;
    logic              last_result;

    modport source (output valid, fitted_value, slope, intercept, residual_sum,
                    degenerate, last_result, input ready);
    modport sink   (input valid, fitted_value, slope, intercept, residual_sum,
                    degenerate, last_result, output ready);
endinterface

// ----- sv/lrf_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on lrf_pkg.
module lrf_div import lrf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W:0]   rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   shifted;
    logic             ge;

    // Load operands on start, else one shift and compare-subtract step
    always_comb
    begin
        shifted   = {rem_reg[DVS_W-1:0], quo_reg[DIV_W-1]};
        ge        = shifted >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold operands
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- sv/lrf_datapath.sv -----
// Datapath: sample stores, running sums, fit arithmetic and residual pass.
// Depends on lrf_pkg and lrf_div.
module lrf_datapath import lrf_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  lrf_cmd_t          cmd,
    output lrf_stat_t         stat,
    input  sample_t           x_value,
    input  sample_t           y_value,
    output fix_t              fitted_value,
    output fix_t              slope,
    output fix_t              intercept,
    output logic [RSUM_W-1:0] residual_sum,
    output logic              degenerate
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = $clog2(MAX_POINTS);

    // Saturate a magnitude with sign to a signed Q16.16 value
    function automatic fix_t sign_sat(input logic [DIV_W-1:0] m, input logic neg);
        logic big;
        big = |m[DIV_W-1:FIX_W-1];
        if (big)
            sign_sat = neg ? fix_t'({1'b1, {(FIX_W-1){1'b0}}})
                           : fix_t'({1'b0, {(FIX_W-1){1'b1}}});
        else
            sign_sat = neg ? -fix_t'(m[FIX_W-1:0]) : fix_t'(m[FIX_W-1:0]);
    endfunction

    sample_t x_mem [MAX_POINTS];
    sample_t y_mem [MAX_POINTS];

    logic [CNT_W-1:0]          count_reg;
    logic signed [SUMX_W-1:0]  sum_x_reg, sum_y_reg;
    logic signed [SUMXX_W-1:0] sum_xx_reg, sum_xy_reg;
    logic [ADDR_W-1:0]         idx_reg;
    logic [RSUM_W-1:0]         rsum_reg;

    logic signed [PROD_W-1:0]  nxx_reg, sxsx_reg, nxy_reg, sxsy_reg;
    logic signed [SXX_W-1:0]   sxx_reg, sxy_reg;
    fix_t                      slope_reg, icpt_reg;
    logic signed [NUM_W-2:0]   prodi_reg;
    logic signed [NUM_W-1:0]   num_reg;
    sample_t                   x_rd_reg, y_rd_reg;
    logic signed [FIX_W+SAMPLE_BITS-1:0] pf_reg;
    fix_t                      fit_reg;
    logic [2*FIX_W-1:0]        sq_reg;

    logic                      full;
    logic signed [NEXT_W-1:0]  n_ext;
    logic signed [2*SAMPLE_BITS-1:0] pxx, pxy;
    logic [SXX_W-1:0]          sxy_mag;
    logic [NUM_W-1:0]          num_mag;
    logic [DIV_W-1:0]          div_dividend, div_quot, slope_rnd;
    logic [DVS_W-1:0]          div_divisor;
    logic                      div_go, div_done;
    logic signed [FIX_W+SAMPLE_BITS:0] fit_sum;
    fix_t                      fit_sat;
    logic signed [FIX_W+1:0]   resid;
    logic [FIX_W+1:0]          resid_mag;
    logic [FIX_W-1:0]          resid_clip;
    logic [RSUM_W-1:0]         term;
    logic [RSUM_W:0]           rsum_wide;
    logic                      degen;

    assign full  = (count_reg == CNT_W'(MAX_POINTS));
    assign n_ext = $signed({{(NEXT_W-CNT_W){1'b0}}, count_reg});
    assign pxx   = x_value * x_value;
    assign pxy   = x_value * y_value;
    assign degen = sxx_reg[SXX_W-1] || (sxx_reg == '0);

    // Divider operands: slope first, then intercept
    always_comb
    begin
        sxy_mag   = sxy_reg[SXX_W-1] ? SXX_W'(-sxy_reg) : SXX_W'(sxy_reg);
        num_mag   = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        slope_rnd = (div_quot >> 1) + DIV_W'(div_quot[0]);
        if (cmd.idiv_go)
        begin
            div_dividend = DIV_W'(num_mag) + DIV_W'(count_reg >> 1);
            div_divisor  = DVS_W'(count_reg);
        end
        else
        begin
            div_dividend = {sxy_mag, {(DIV_W-SXX_W){1'b0}}};
            div_divisor  = sxx_reg[DVS_W-1:0];
        end
    end

    assign div_go = cmd.sdiv_go || cmd.idiv_go;

    lrf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Per-point fitted value and squared residual
    always_comb
    begin
        fit_sum = $signed({icpt_reg[FIX_W-1], {SAMPLE_BITS{icpt_reg[FIX_W-1]}}, icpt_reg})
                + $signed({pf_reg[FIX_W+SAMPLE_BITS-1], pf_reg});
        if (fit_sum[FIX_W+SAMPLE_BITS:FIX_W-1] == '0
            || fit_sum[FIX_W+SAMPLE_BITS:FIX_W-1] == '1)
            fit_sat = fit_sum[FIX_W-1:0];
        else
            fit_sat = fit_sum[FIX_W+SAMPLE_BITS] ? fix_t'({1'b1, {(FIX_W-1){1'b0}}})
                                                 : fix_t'({1'b0, {(FIX_W-1){1'b1}}});
        resid = $signed({{2{fit_reg[FIX_W-1]}}, fit_reg})
              - $signed({{2{y_rd_reg[SAMPLE_BITS-1]}}, y_rd_reg, {FRAC_W{1'b0}}});
        resid_mag  = resid[FIX_W+1] ? (FIX_W+2)'(-resid) : (FIX_W+2)'(resid);
        resid_clip = (|resid_mag[FIX_W+1:FIX_W]) ? '1 : resid_mag[FIX_W-1:0];
        term       = {{FRAC_W{1'b0}}, sq_reg[2*FIX_W-1:FRAC_W]} + RSUM_W'(sq_reg[FRAC_W-1]);
        rsum_wide  = {1'b0, rsum_reg} + {1'b0, term};
    end

    // Store an accepted pair; read the pair at the point index
    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
        begin
            x_mem[count_reg[ADDR_W-1:0]] <= x_value;
            y_mem[count_reg[ADDR_W-1:0]] <= y_value;
        end
        if (cmd.rd)
        begin
            x_rd_reg <= x_mem[idx_reg];
            y_rd_reg <= y_mem[idx_reg];
        end
    end

    // Advance count, sums, point index and residual sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_xy_reg <= '0;
            idx_reg    <= '0;
            rsum_reg   <= '0;
        end
        else
        begin
            if (cmd.clr_set)
            begin
                count_reg  <= '0;
                sum_x_reg  <= '0;
                sum_y_reg  <= '0;
                sum_xx_reg <= '0;
                sum_xy_reg <= '0;
            end
            else if (cmd.load && !full)
            begin
                count_reg  <= count_reg + CNT_W'(1);
                sum_x_reg  <= sum_x_reg + SUMX_W'(x_value);
                sum_y_reg  <= sum_y_reg + SUMX_W'(y_value);
                sum_xx_reg <= sum_xx_reg + SUMXX_W'(pxx);
                sum_xy_reg <= sum_xy_reg + SUMXX_W'(pxy);
            end
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + ADDR_W'(1);
            if (cmd.sum_mul)
                rsum_reg <= '0;
            else if (cmd.acc)
                rsum_reg <= rsum_wide[RSUM_W] ? '1 : rsum_wide[RSUM_W-1:0];
        end
    end

    // Fit arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.sum_mul)
        begin
            nxx_reg  <= n_ext * sum_xx_reg;
            sxsx_reg <= sum_x_reg * sum_x_reg;
            nxy_reg  <= n_ext * sum_xy_reg;
            sxsy_reg <= sum_x_reg * sum_y_reg;
        end
        if (cmd.sum_sub)
        begin
            sxx_reg <= SXX_W'(nxx_reg) - SXX_W'(sxsx_reg);
            sxy_reg <= SXX_W'(nxy_reg) - SXX_W'(sxsy_reg);
        end
        if (cmd.slope_take)
            slope_reg <= sign_sat(slope_rnd, sxy_reg[SXX_W-1]);
        if (cmd.icpt_mul)
            prodi_reg <= slope_reg * sum_x_reg;
        if (cmd.icpt_num)
            num_reg <= $signed({sum_y_reg, {FRAC_W{1'b0}}}) - prodi_reg;
        if (cmd.icpt_take)
            icpt_reg <= sign_sat(div_quot, num_reg[NUM_W-1]);
        if (cmd.mul)
            pf_reg <= slope_reg * x_rd_reg;
        if (cmd.fit)
            fit_reg <= fit_sat;
        if (cmd.sq)
            sq_reg <= resid_clip * resid_clip;
    end

    assign stat.degen    = degen;
    assign stat.div_done = div_done;
    assign stat.idx_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // Result fields; a degenerate set reports zeros
    assign fitted_value = degen ? '0 : fit_reg;
    assign slope        = degen ? '0 : slope_reg;
    assign intercept    = degen ? '0 : icpt_reg;
    assign residual_sum = degen ? '0 : rsum_reg;
    assign degenerate   = degen;

endmodule

// ----- sv/lrf_ctrl.sv -----
// Controller state machine: load, fit sequence, residual and emit passes.
// Depends on lrf_pkg.
module lrf_ctrl import lrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_last,
    input  logic      out_ready,
    input  lrf_stat_t stat,
    output logic      in_ready,
    output logic      out_valid,
    output lrf_cmd_t  cmd
);

    typedef enum logic [17:0] {
        S_LOAD      = 18'h00001,
        S_SUMMUL    = 18'h00002,
        S_SUMSUB    = 18'h00004,
        S_SDIV_GO   = 18'h00008,
        S_SDIV_WAIT = 18'h00010,
        S_ICPT_MUL  = 18'h00020,
        S_ICPT_NUM  = 18'h00040,
        S_IDIV_GO   = 18'h00080,
        S_IDIV_WAIT = 18'h00100,
        S_R_RD      = 18'h00200,
        S_R_MUL     = 18'h00400,
        S_R_FIT     = 18'h00800,
        S_R_SQ      = 18'h01000,
        S_R_ACC     = 18'h02000,
        S_E_RD      = 18'h04000,
        S_E_MUL     = 18'h08000,
        S_E_FIT     = 18'h10000,
        S_E_OUT     = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    // Sequence the fit and the two passes over the stored points
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD:
            begin
                cmd.load = in_valid;
                if (in_valid && in_last)
                    state_next = S_SUMMUL;
            end
            S_SUMMUL:
            begin
                cmd.sum_mul = 1'b1;
                cmd.idx_clr = 1'b1;
                state_next  = S_SUMSUB;
            end
            S_SUMSUB:
            begin
                cmd.sum_sub = 1'b1;
                state_next  = S_SDIV_GO;
            end
            S_SDIV_GO:
            begin
                if (stat.degen)
                    state_next = S_E_RD;
                else
                begin
                    cmd.sdiv_go = 1'b1;
                    state_next  = S_SDIV_WAIT;
                end
            end
            S_SDIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.slope_take = 1'b1;
                    state_next     = S_ICPT_MUL;
                end
            end
            S_ICPT_MUL:
            begin
                cmd.icpt_mul = 1'b1;
                state_next   = S_ICPT_NUM;
            end
            S_ICPT_NUM:
            begin
                cmd.icpt_num = 1'b1;
                state_next   = S_IDIV_GO;
            end
            S_IDIV_GO:
            begin
                cmd.idiv_go = 1'b1;
                state_next  = S_IDIV_WAIT;
            end
            S_IDIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.icpt_take = 1'b1;
                    state_next    = S_R_RD;
                end
            end
            S_R_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_R_MUL;
            end
            S_R_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_R_FIT;
            end
            S_R_FIT:
            begin
                cmd.fit    = 1'b1;
                state_next = S_R_SQ;
            end
            S_R_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = S_R_ACC;
            end
            S_R_ACC:
            begin
                cmd.acc = 1'b1;
                if (stat.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_E_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_R_RD;
                end
            end
            S_E_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_E_MUL;
            end
            S_E_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_E_FIT;
            end
            S_E_FIT:
            begin
                cmd.fit    = 1'b1;
                state_next = S_E_OUT;
            end
            S_E_OUT:
            begin
                if (out_ready)
                begin
                    if (stat.idx_last)
                    begin
                        cmd.clr_set = 1'b1;
                        state_next  = S_LOAD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_E_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_E_OUT);

endmodule

// ----- sv/linear_regression_fit.sv -----
// Least-squares line fit. Loading takes one item per cycle. After the last item
// the shared divider does two 64-step runs; per point, the residual pass reads,
// multiplies, fits, squares and accumulates, the emit pass reads, multiplies,
// fits and shows its result, which the output can stall. Zero x variance skips
// the divider and the residual pass. Reset (rst_n low, asynchronous) empties
// the set and returns to loading; the sample stores are not cleared.
module linear_regression_fit import lrf_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    lrf_in_if.sink    samples,
    lrf_out_if.source results
);

    lrf_cmd_t  cmd;
    lrf_stat_t stat;

    lrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_last   (samples.last_point),
        .out_ready (results.ready),
        .stat      (stat),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .cmd       (cmd)
    );

    lrf_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .x_value      (samples.x_value),
        .y_value      (samples.y_value),
        .fitted_value (results.fitted_value),
        .slope        (results.slope),
        .intercept    (results.intercept),
        .residual_sum (results.residual_sum),
        .degenerate   (results.degenerate)
    );

    assign results.last_result = stat.idx_last;

    // Loading and emitting never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(samples.ready && results.valid))
        else $error("input ready while a result item is shown");

    // A degenerate result carries zero fit fields
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.degenerate |->
            results.slope == '0 && results.intercept == '0
            && results.residual_sum == '0 && results.fitted_value == '0)
        else $error("degenerate result with nonzero fit");

    // The final result item returns the block to loading
    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.ready && results.last_result |=> samples.ready)
        else $error("not loading after the final result item");

endmodule
